>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/dq_pkg.sv
package dq_pkg;

    localparam int CAPACITY      = 64;
    localparam int ELEMENT_WIDTH = 8;
    localparam int IDX_W         = $clog2(CAPACITY);
    localparam int COUNT_W       = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        OP_PUSH_BACK  = 2'd0,
        OP_PUSH_FRONT = 2'd1,
        OP_POP_BACK   = 2'd2,
        OP_POP_FRONT  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_LOAD
    } fsm_state_t;

    typedef struct packed {
        op_t                      operation;
        logic [ELEMENT_WIDTH-1:0] push_value;
    } req_beat_t;

    typedef struct packed {
        logic [ELEMENT_WIDTH-1:0] front_value;
        logic [ELEMENT_WIDTH-1:0] back_value;
        logic [COUNT_W-1:0]       entry_count;
        logic                     is_empty;
        status_t                  status;
    } rsp_beat_t;

    typedef struct packed {
        logic                     we;
        logic [IDX_W-1:0]         waddr;
        logic [ELEMENT_WIDTH-1:0] wdata;
        logic                     re;
        logic [IDX_W-1:0]         raddr_front;
        logic [IDX_W-1:0]         raddr_back;
    } mem_req_t;

    function automatic logic [IDX_W-1:0] idx_up(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(CAPACITY - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] idx_down(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(CAPACITY - 1) : i - 1'b1;
    endfunction

endpackage

>>> hw/rtl/double_ended_queue_top.sv
// Bounded double-ended queue in a ring buffer with one write port and two
// read ports. Each request beat pushes or pops at either end and yields one
// response beat carrying the front and back elements after the operation
// (zero when empty), the entry count, an empty flag and a status (done,
// underflow, or overflow when a push meets a full queue and is dropped).
// A request passes through the update of the pointers with the store
// write, the registered read of both ends from the store, then the load of the
// response register, which waits until the previous response is taken.
// The response register lets a new request in while the previous response
// waits to be taken. The store needs no clearing after reset.
`include "assert_macros.svh"

module double_ended_queue_top
    import dq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_beat_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_beat_t rsp
);

    mem_req_t                 mem_req;
    logic [ELEMENT_WIDTH-1:0] rdata_front;
    logic [ELEMENT_WIDTH-1:0] rdata_back;

    dq_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .mem_req     (mem_req),
        .rdata_front (rdata_front),
        .rdata_back  (rdata_back)
    );

    dq_store u_store (
        .clk         (clk),
        .mem_req     (mem_req),
        .rdata_front (rdata_front),
        .rdata_back  (rdata_back)
    );

    `ASSERT_NEXT(a_busy_after_req, clk, rst_n, req_valid && req_ready, !req_ready)
    `ASSERT_IMPLIES(a_empty_zero, clk, rst_n, rsp_valid && rsp.is_empty, (rsp.front_value == '0) && (rsp.back_value == '0))
    `ASSERT_IMPLIES(a_empty_count, clk, rst_n, rsp_valid, rsp.is_empty == (rsp.entry_count == '0))
    `ASSERT_IMPLIES(a_overflow_full, clk, rst_n, rsp_valid && (rsp.status == ST_OVERFLOW), rsp.entry_count == COUNT_W'(CAPACITY))
    `ASSERT_IMPLIES(a_underflow_empty, clk, rst_n, rsp_valid && (rsp.status == ST_UNDERFLOW), rsp.is_empty)

endmodule

>>> hw/rtl/dq_store.sv
module dq_store
    import dq_pkg::*;
(
    input  logic                     clk,
    input  mem_req_t                 mem_req,
    output logic [ELEMENT_WIDTH-1:0] rdata_front,
    output logic [ELEMENT_WIDTH-1:0] rdata_back
);

    logic [ELEMENT_WIDTH-1:0] mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            mem[mem_req.waddr] <= mem_req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_req.re)
        begin
            rdata_front <= mem[mem_req.raddr_front];
            rdata_back  <= mem[mem_req.raddr_back];
        end
    end

endmodule

>>> hw/rtl/dq_ctrl.sv
module dq_ctrl
    import dq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_ready,
    input  req_beat_t                req,
    output logic                     rsp_valid,
    input  logic                     rsp_ready,
    output rsp_beat_t                rsp,
    output mem_req_t                 mem_req,
    input  logic [ELEMENT_WIDTH-1:0] rdata_front,
    input  logic [ELEMENT_WIDTH-1:0] rdata_back
);

    fsm_state_t         state_reg, state_next;
    logic [IDX_W-1:0]   front_reg, front_next;
    logic [IDX_W-1:0]   back_reg, back_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    status_t            status_reg, status_next;
    rsp_beat_t          rsp_reg, rsp_next;
    logic               rsp_valid_reg, rsp_valid_next;

    logic req_fire;
    logic rsp_free;
    logic is_full;
    logic is_void;

    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign rsp_free  = !rsp_valid_reg || rsp_ready;
    assign is_full   = (count_reg == COUNT_W'(CAPACITY));
    assign is_void   = (count_reg == '0);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (rsp_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        front_next          = front_reg;
        back_next           = back_reg;
        count_next          = count_reg;
        status_next         = status_reg;
        rsp_next            = rsp_reg;
        rsp_valid_next      = rsp_valid_reg && !rsp_ready;
        mem_req             = '0;
        mem_req.wdata       = req.push_value;
        mem_req.raddr_front = front_reg;
        mem_req.raddr_back  = idx_down(back_reg);
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    status_next = ST_DONE;
                    case (req.operation)
                        OP_PUSH_BACK:
                        begin
                            if (is_full)
                            begin
                                status_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = back_reg;
                                back_next     = idx_up(back_reg);
                                count_next    = count_reg + 1'b1;
                            end
                        end
                        OP_PUSH_FRONT:
                        begin
                            if (is_full)
                            begin
                                status_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = idx_down(front_reg);
                                front_next    = idx_down(front_reg);
                                count_next    = count_reg + 1'b1;
                            end
                        end
                        OP_POP_BACK:
                        begin
                            if (is_void)
                            begin
                                status_next = ST_UNDERFLOW;
                            end
                            else
                            begin
                                back_next  = idx_down(back_reg);
                                count_next = count_reg - 1'b1;
                            end
                        end
                        OP_POP_FRONT:
                        begin
                            if (is_void)
                            begin
                                status_next = ST_UNDERFLOW;
                            end
                            else
                            begin
                                front_next = idx_up(front_reg);
                                count_next = count_reg - 1'b1;
                            end
                        end
                        default:
                        begin
                            status_next = ST_DONE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                mem_req.re = 1'b1;
            end
            S_LOAD:
            begin
                if (rsp_free)
                begin
                    rsp_next.front_value = is_void ? '0 : rdata_front;
                    rsp_next.back_value  = is_void ? '0 : rdata_back;
                    rsp_next.entry_count = count_reg;
                    rsp_next.is_empty    = is_void;
                    rsp_next.status      = status_reg;
                    rsp_valid_next       = 1'b1;
                end
            end
            default:
            begin
                mem_req.re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            back_reg      <= '0;
            count_reg     <= '0;
            status_reg    <= ST_DONE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            back_reg      <= back_next;
            count_reg     <= count_next;
            status_reg    <= status_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import dq_pkg::*;

    localparam int FIFO_AW    = 11;
    localparam int FIFO_DEPTH = 2048;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    req_beat_t req = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    rsp_beat_t rsp;

    double_ended_queue_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // Shadow deque
    logic [ELEMENT_WIDTH-1:0] shadow_store [CAPACITY];
    logic [IDX_W-1:0]         shadow_front;
    logic [IDX_W-1:0]         shadow_back;
    logic [COUNT_W-1:0]       shadow_count;

    // Pending request beats and expected response beats, as rings
    req_beat_t pending_reqs [FIFO_DEPTH];
    rsp_beat_t expected_rsp [FIFO_DEPTH];
    int        pend_wr = 0;
    int        pend_rd = 0;
    int        exp_wr  = 0;
    int        exp_rd  = 0;

    bit hold_sender = 1'b0;
    bit no_idle     = 1'b0;
    int gen_count   = 0;

    int beats_sent     = 0;
    int beats_checked  = 0;
    int error_count    = 0;
    int underflow_seen = 0;
    int overflow_seen  = 0;
    int peak_fill      = 0;

    function automatic logic [IDX_W-1:0] slot_up(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(CAPACITY - 1)) ? '0 : IDX_W'(i + 1);
    endfunction

    function automatic logic [IDX_W-1:0] slot_down(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(CAPACITY - 1) : IDX_W'(i - 1);
    endfunction

    function automatic rsp_beat_t deque_apply(input req_beat_t beat);
        rsp_beat_t out;
        status_t   st;
        st = ST_DONE;
        case (beat.operation)
            OP_PUSH_BACK, OP_PUSH_FRONT:
            begin
                if (shadow_count == COUNT_W'(CAPACITY))
                begin
                    st = ST_OVERFLOW;
                end
                else if (beat.operation == OP_PUSH_BACK)
                begin
                    shadow_store[shadow_back] = beat.push_value;
                    shadow_back = slot_up(shadow_back);
                    shadow_count = shadow_count + 1'b1;
                end
                else
                begin
                    shadow_front = slot_down(shadow_front);
                    shadow_store[shadow_front] = beat.push_value;
                    shadow_count = shadow_count + 1'b1;
                end
            end
            default:
            begin
                if (shadow_count == '0)
                begin
                    st = ST_UNDERFLOW;
                end
                else if (beat.operation == OP_POP_BACK)
                begin
                    shadow_back = slot_down(shadow_back);
                    shadow_count = shadow_count - 1'b1;
                end
                else
                begin
                    shadow_front = slot_up(shadow_front);
                    shadow_count = shadow_count - 1'b1;
                end
            end
        endcase
        if (shadow_count == '0)
        begin
            out.front_value = '0;
            out.back_value  = '0;
        end
        else
        begin
            out.front_value = shadow_store[shadow_front];
            out.back_value  = shadow_store[slot_down(shadow_back)];
        end
        out.entry_count = shadow_count;
        out.is_empty    = (shadow_count == '0);
        out.status      = st;
        if (st == ST_UNDERFLOW)
            underflow_seen++;
        if (st == ST_OVERFLOW)
            overflow_seen++;
        if (int'(shadow_count) > peak_fill)
            peak_fill = int'(shadow_count);
        return out;
    endfunction

    task automatic report_mismatch(input int n, input rsp_beat_t e, input rsp_beat_t a);
        $display("ERROR: beat %0d expected front %h back %h count %0d empty %b status %0d",
            n, e.front_value, e.back_value, e.entry_count, e.is_empty, e.status);
        $display("       beat %0d actual   front %h back %h count %0d empty %b status %0d",
            n, a.front_value, a.back_value, a.entry_count, a.is_empty, a.status);
    endtask

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
            shadow_front = '0;
            shadow_back  = '0;
            shadow_count = '0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                expected_rsp[exp_wr[FIFO_AW-1:0]] = deque_apply(req);
                exp_wr++;
                beats_sent++;
            end
            if (!req_valid || req_ready)
            begin
                if (pend_wr != pend_rd && !hold_sender &&
                    (no_idle || $urandom_range(0, 99) >= 35))
                begin
                    req_valid <= 1'b1;
                    req       <= pending_reqs[pend_rd[FIFO_AW-1:0]];
                    pend_rd++;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor
    always @(posedge clk or negedge rst_n)
    begin
        rsp_beat_t want;
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (exp_wr == exp_rd)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("ERROR: unexpected response beat %p", rsp);
                end
                else
                begin
                    want = expected_rsp[exp_rd[FIFO_AW-1:0]];
                    exp_rd++;
                    beats_checked++;
                    if (rsp.front_value !== want.front_value ||
                        rsp.back_value  !== want.back_value  ||
                        rsp.entry_count !== want.entry_count ||
                        rsp.is_empty    !== want.is_empty    ||
                        rsp.status      !== want.status)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            report_mismatch(beats_checked, want, rsp);
                    end
                end
            end
            rsp_ready <= no_idle || ($urandom_range(0, 99) >= 35);
        end
    end

    task automatic add_beat(input op_t op, input logic [ELEMENT_WIDTH-1:0] v);
        req_beat_t b;
        b.operation  = op;
        b.push_value = v;
        pending_reqs[pend_wr[FIFO_AW-1:0]] = b;
        pend_wr++;
        if (op == OP_PUSH_BACK || op == OP_PUSH_FRONT)
        begin
            if (gen_count < CAPACITY)
                gen_count++;
        end
        else if (gen_count > 0)
        begin
            gen_count--;
        end
    endtask

    task automatic add_random(input op_t op);
        add_beat(op, ELEMENT_WIDTH'($urandom_range(0, 255)));
    endtask

    // Fill to full, drain to empty, or mixed runs; every batch opens with a fill.
    task automatic gen_batch(input int n);
        int added;
        int mode;
        int len;
        int push_pct;
        added = 0;
        mode  = 0;
        while (added < n)
        begin
            case (mode)
                0:
                begin
                    while (gen_count < CAPACITY)
                    begin
                        add_random($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK);
                        added++;
                    end
                    len = $urandom_range(1, 3);
                    repeat (len)
                    begin
                        add_random($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK);
                        added++;
                    end
                end
                1:
                begin
                    while (gen_count > 0)
                    begin
                        add_random($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK);
                        added++;
                    end
                    len = $urandom_range(1, 3);
                    repeat (len)
                    begin
                        add_random($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK);
                        added++;
                    end
                end
                default:
                begin
                    len = $urandom_range(16, 64);
                    push_pct = (mode == 2) ? 50 : ((mode == 3) ? 70 : 30);
                    repeat (len)
                    begin
                        if ($urandom_range(0, 99) < push_pct)
                            add_random($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK);
                        else
                            add_random($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK);
                        added++;
                    end
                end
            endcase
            mode = $urandom_range(0, 4);
        end
    endtask

    task automatic wait_drained();
        while (pend_wr != pend_rd || req_valid || exp_wr != exp_rd)
            @(negedge clk);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // underflow at both ends, extremes, index wrap in both directions
        add_beat(OP_POP_BACK, 8'h00);
        add_beat(OP_POP_FRONT, 8'hFF);
        add_beat(OP_PUSH_BACK, 8'h00);
        add_beat(OP_PUSH_BACK, 8'hFF);
        add_beat(OP_PUSH_FRONT, 8'h80);
        add_beat(OP_PUSH_FRONT, 8'h01);
        add_beat(OP_POP_BACK, 8'hFF);
        add_beat(OP_POP_FRONT, 8'h00);
        add_beat(OP_POP_FRONT, 8'hFF);
        add_beat(OP_POP_BACK, 8'h00);
        add_beat(OP_POP_FRONT, 8'h00);
        add_beat(OP_PUSH_FRONT, 8'hAA);
        add_beat(OP_POP_BACK, 8'h00);
        add_beat(OP_PUSH_BACK, 8'h55);
        add_beat(OP_POP_FRONT, 8'h00);
        add_beat(OP_PUSH_FRONT, 8'h7F);
        add_beat(OP_PUSH_BACK, 8'hFE);
        add_beat(OP_POP_FRONT, 8'h00);
        add_beat(OP_POP_FRONT, 8'h00);
        add_beat(OP_POP_BACK, 8'hFF);

        gen_batch(500);

        // sender holds off until the deque has answered everything
        while (pend_wr != pend_rd || req_valid)
            @(negedge clk);
        hold_sender = 1'b1;
        gen_batch(450);
        while (exp_wr != exp_rd)
            @(negedge clk);
        repeat (5) @(negedge clk);
        no_idle     = 1'b1;
        hold_sender = 1'b0;

        while (pend_wr != pend_rd)
            @(negedge clk);
        no_idle = 1'b0;
        gen_batch(480);

        wait_drained();
        repeat (20) @(negedge clk);

        $display("Sent %0d beats, checked %0d: %0d underflows, %0d overflows, peak %0d",
            beats_sent, beats_checked, underflow_seen, overflow_seen, peak_fill);
        $display("Errors %0d, responses still outstanding %0d",
            error_count, exp_wr - exp_rd);
        if (error_count == 0 && exp_wr == exp_rd)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("Timeout with %0d responses outstanding", exp_wr - exp_rd);
        $display("Verification failed");
        $finish;
    end

endmodule
